>>> rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte-forming helpers for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int MaxBytes = 6;
  localparam int CountW   = 3;

  localparam logic [15:0] MaskAscii = 16'hFF80;
  localparam logic [15:0] MaskTwo   = 16'hF800;
  localparam logic [15:0] MaskSurr  = 16'hFC00;
  localparam logic [15:0] HighSurr  = 16'hD800;
  localparam logic [15:0] LowSurr   = 16'hDC00;

  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Cont  = 8'h80;
  localparam logic [7:0] Six   = 8'h3F;

  typedef logic [2:0][7:0] byte3_t;

  // One pending run of bytes; entry 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic byte3_t three_byte(input logic [15:0] u);
    byte3_t b;
    b[0] = {4'h0, u[15:12]} | Lead3;
    b[1] = ({2'b00, u[11:6]} & Six) | Cont;
    b[2] = ({2'b00, u[5:0]} & Six) | Cont;
    return b;
  endfunction

endpackage

>>> rtl/u16u8_in_if.sv
// ----------------------------------------------------------------------------
// u16u8_in_if
// Channel carrying one UTF-16 code unit per word.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

>>> rtl/u16u8_out_if.sv
// ----------------------------------------------------------------------------
// u16u8_out_if
// Channel carrying one UTF-8 byte per word, flagged on the last of a run.
// ----------------------------------------------------------------------------
interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a held high surrogate and turns each other unit
// into a run of bytes for the queue.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  u16u8_in_if.sink   code,
  input  q_status_t  qs,
  output logic       push,
  output job_t       job
);

  logic        held_valid;
  logic [15:0] held_high_unit;
  logic        held_valid_next;

  logic [15:0] u;
  logic        is_low;
  logic        is_high;
  logic        accept;
  logic [20:0] cp;
  byte3_t      new_bytes;
  logic [CountW-1:0] new_cnt;

  assign u          = code.code_unit;
  assign code.ready = !qs.full;
  assign accept     = code.valid && code.ready;
  assign is_low     = (u & MaskSurr) == LowSurr;
  assign is_high    = (u & MaskSurr) == HighSurr;
  assign cp         = 21'h10000 + {1'b0, held_high_unit[9:0], u[9:0]};

  always_comb begin
    new_bytes = '0;
    new_cnt   = '0;
    if (u == 16'd0) begin
      new_cnt = CountW'(1);
    end else if (is_high) begin
      new_cnt = '0;
    end else if ((u & MaskAscii) == 16'd0) begin
      new_bytes[0] = u[7:0];
      new_cnt      = CountW'(1);
    end else if ((u & MaskTwo) == 16'd0) begin
      new_bytes[0] = {3'b000, u[10:6]} | Lead2;
      new_bytes[1] = ({2'b00, u[5:0]} & Six) | Cont;
      new_cnt      = CountW'(2);
    end else begin
      new_bytes = three_byte(u);
      new_cnt   = CountW'(3);
    end
  end

  always_comb begin
    job             = '0;
    held_valid_next = held_valid;
    if (held_valid && is_low) begin
      job.bytes[0]    = {5'd0, cp[20:18]} | Lead4;
      job.bytes[1]    = {2'b00, cp[17:12]} | Cont;
      job.bytes[2]    = {2'b00, cp[11:6]} | Cont;
      job.bytes[3]    = {2'b00, cp[5:0]} | Cont;
      job.count       = CountW'(4);
      held_valid_next = 1'b0;
    end else begin
      // A held unit that is not completed goes out first as its own 3-byte form.
      if (held_valid) begin
        job.bytes[2:0] = three_byte(held_high_unit);
        job.bytes[5:3] = new_bytes;
        job.count      = new_cnt + CountW'(3);
      end else begin
        job.bytes[2:0] = new_bytes;
        job.count      = new_cnt;
      end
      held_valid_next = is_high;
    end
  end

  assign push = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_unit <= '0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      if (is_high) begin
        held_high_unit <= u;
      end
    end
  end

endmodule

>>> rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short first-in first-out queue of byte runs between front and back.
// ----------------------------------------------------------------------------
module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t qs
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] cnt;

  assign qs.full  = cnt == CntW'(DEPTH);
  assign qs.empty = cnt == '0;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CntW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Takes byte runs from the queue and sends them out one byte per word.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  q_status_t  qs,
  output logic       pop,
  u16u8_out_if.source utf8
);

  job_t              cur;
  logic              active;
  logic [CountW-1:0] idx;
  logic              last;
  logic              fire;

  assign last             = idx == (cur.count - CountW'(1));
  assign fire             = active && utf8.ready;
  assign utf8.valid       = active;
  assign utf8.out_byte    = cur.bytes[idx];
  assign utf8.last_of_run = last;

  // The next run loads on the same edge the final byte of this one leaves.
  assign pop = !qs.empty && (!active || (fire && last));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (fire) begin
      if (last) begin
        active <= 1'b0;
        idx    <= '0;
      end else begin
        idx <= idx + CountW'(1);
      end
    end
  end

endmodule

>>> rtl/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing.
// ----------------------------------------------------------------------------
// Each accepted code unit yields a run of bytes: one for ASCII or the zero
// terminator, two or three for other units, four for a completed surrogate
// pair, and up to six when an unpaired high surrogate is flushed ahead of the
// new unit; a held high surrogate yields no bytes. The output register sends
// one byte per cycle while the receiver is ready and loads the next run on
// the edge the last byte leaves. Input is taken in the same cycle it arrives
// while the run queue (QUEUE_DEPTH entries) has room, so new units are taken
// while earlier runs are still going out. The last byte of each unit's run
// has last_of_run set.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input logic          clk,
  input logic          rst,
  u16u8_in_if.sink     code,
  u16u8_out_if.source  utf8
);

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t qs;

  u16u8_front u_front (
    .clk  (clk),
    .rst  (rst),
    .code (code),
    .qs   (qs),
    .push (push),
    .job  (push_job)
  );

  u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  u16u8_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qs   (qs),
    .pop  (pop),
    .utf8 (utf8)
  );

  a_q_sane: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qs.empty)
    else $error("run taken from an empty queue");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (utf8.valid && utf8.ready && !utf8.last_of_run) |=> utf8.valid)
    else $error("byte run broken before its last byte");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    code.ready == !qs.full)
    else $error("input ready does not follow queue room");

endmodule

>>> tb/utf16_to_utf8_encoder_test.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_test
// Self-checking bench for the UTF-16 to UTF-8 encoder. Code units go in
// through a bursty sender and bytes come out to a receiver that stalls. An
// in-bench encoder predicts every byte and its last-of-run flag, and each
// accepted output word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_test;
  import u16u8_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles = 5;
  localparam int LongHold    = 300;
  localparam int StallLimit  = 2000;
  localparam int TailCycles  = 20;
  localparam int RandomUnits = 160;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } utf8_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u16u8_in_if  code_ch ();
  u16u8_out_if utf8_ch ();

  utf16_to_utf8_encoder DUT (
    .clk  (clk),
    .rst  (rst),
    .code (code_ch),
    .utf8 (utf8_ch)
  );

  logic [15:0] unit_queue[$];
  utf8_byte_t  utf8_bytes_due[$];

  // Encoder state mirrored by the bench.
  logic        high_held;
  logic [15:0] held_high;

  int mismatch_count = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int flow_left      = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int holds_asked    = 0;
  int holds_started  = 0;
  int quiet_cycles   = 0;

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_three(ref utf8_byte_t run[$], input logic [15:0] v);
    run.push_back('{Lead3 | {4'h0, v[15:12]}, 1'b0});
    run.push_back('{Cont | {2'b00, v[11:6]}, 1'b0});
    run.push_back('{Cont | {2'b00, v[5:0]}, 1'b0});
  endtask

  // Works out the bytes one accepted code unit causes and queues them.
  task automatic encode_code_unit(input logic [15:0] u);
    utf8_byte_t  run[$];
    logic [20:0] cp;
    logic [15:0] h;
    bit          paired;
    paired = 0;
    if (high_held) begin
      h = held_high;
      high_held = 1'b0;
      held_high = '0;
      if ((u & MaskSurr) == LowSurr) begin
        cp = 21'h10000 + {1'b0, h[9:0], u[9:0]};
        run.push_back('{Lead4 | {5'b0, cp[20:18]}, 1'b0});
        run.push_back('{Cont | {2'b00, cp[17:12]}, 1'b0});
        run.push_back('{Cont | {2'b00, cp[11:6]}, 1'b0});
        run.push_back('{Cont | {2'b00, cp[5:0]}, 1'b0});
        paired = 1;
      end else begin
        push_three(run, h);
      end
    end
    if (!paired) begin
      if (u == '0) begin
        run.push_back('{8'h00, 1'b0});
      end else if ((u & MaskSurr) == HighSurr) begin
        high_held = 1'b1;
        held_high = u;
      end else if ((u & MaskAscii) == '0) begin
        run.push_back('{u[7:0], 1'b0});
      end else if ((u & MaskTwo) == '0) begin
        run.push_back('{Lead2 | {3'b000, u[10:6]}, 1'b0});
        run.push_back('{Cont | {2'b00, u[5:0]}, 1'b0});
      end else begin
        push_three(run, u);
      end
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last_of_run = 1'b1;
    end
    foreach (run[i]) begin
      utf8_bytes_due.push_back(run[i]);
    end
  endtask

  // Mostly well-formed text with random content, plus some broken sequences.
  task automatic queue_random_text(input int n_units);
    int          made;
    int          pick;
    logic [15:0] u;
    made = 0;
    while (made < n_units) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        unit_queue.push_back(16'($urandom_range(1, 16'h7F)));
      end else if (pick < 35) begin
        unit_queue.push_back(16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 55) begin
        u = 16'($urandom_range(16'h800, 16'hFFFF));
        // Move anything in the surrogate range up into the plain 3-byte range.
        if ((u & MaskTwo) == HighSurr) begin
          u = u ^ 16'h2000;
        end
        unit_queue.push_back(u);
      end else if (pick < 75) begin
        unit_queue.push_back(HighSurr | 16'($urandom_range(0, 16'h3FF)));
        unit_queue.push_back(LowSurr | 16'($urandom_range(0, 16'h3FF)));
        made++;
      end else if (pick < 83) begin
        unit_queue.push_back(16'h0000);
      end else if (pick < 89) begin
        unit_queue.push_back(HighSurr | 16'($urandom_range(0, 16'h3FF)));
      end else if (pick < 94) begin
        unit_queue.push_back(LowSurr | 16'($urandom_range(0, 16'h3FF)));
      end else begin
        unit_queue.push_back(16'($urandom_range(0, 16'hFFFF)));
      end
      made++;
    end
  endtask

  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (unit_queue.size() != 0 || code_ch.valid || utf8_bytes_due.size() != 0);
  endtask

  // Sender: bursts of words with random gaps in between.
  always @(posedge clk) begin
    if (rst) begin
      code_ch.valid <= 1'b0;
      code_ch.code_unit <= '0;
    end else if (!code_ch.valid || code_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        code_ch.valid <= 1'b0;
      end else if (unit_queue.size() > 0) begin
        code_ch.valid <= 1'b1;
        code_ch.code_unit <= unit_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        code_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: runs of ready with short stalls, and a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      utf8_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      utf8_ch.ready <= 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started++;
      hold_left = LongHold;
      utf8_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      utf8_ch.ready <= 1'b0;
    end else begin
      utf8_ch.ready <= 1'b1;
      if (flow_left > 0) begin
        flow_left--;
      end else begin
        flow_left = $urandom_range(1, 24);
        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      end
    end
  end

  // Prediction comes before the check, so a word in flight is never missed.
  always @(posedge clk) begin : check_bytes
    utf8_byte_t due;
    if (rst) begin
      high_held = 1'b0;
      held_high = '0;
    end else begin
      if (code_ch.valid && code_ch.ready) begin
        encode_code_unit(code_ch.code_unit);
      end
      if (utf8_ch.valid && utf8_ch.ready) begin
        if (utf8_bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", utf8_ch.out_byte));
        end else begin
          due = utf8_bytes_due.pop_front();
          if (utf8_ch.out_byte !== due.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      utf8_ch.out_byte, due.out_byte));
          end
          if (utf8_ch.last_of_run !== due.last_of_run) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                      utf8_ch.last_of_run, due.last_of_run, due.out_byte));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((code_ch.valid && code_ch.ready) || (utf8_ch.valid && utf8_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no word moved for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    code_ch.valid = 1'b0;
    code_ch.code_unit = '0;
    utf8_ch.ready = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Range edges of each byte length.
    unit_queue.push_back(16'h0001);
    unit_queue.push_back(16'h007F);
    unit_queue.push_back(16'h0080);
    unit_queue.push_back(16'h07FF);
    unit_queue.push_back(16'h0800);
    unit_queue.push_back(16'hD7FF);
    unit_queue.push_back(16'hE000);
    unit_queue.push_back(16'hFFFF);
    // Lowest and highest surrogate pairs.
    unit_queue.push_back(16'hD800);
    unit_queue.push_back(16'hDC00);
    unit_queue.push_back(16'hDBFF);
    unit_queue.push_back(16'hDFFF);
    // Held high surrogate followed by ASCII, then by a 3-byte unit.
    unit_queue.push_back(16'hD83D);
    unit_queue.push_back(16'h0041);
    unit_queue.push_back(16'hDA00);
    unit_queue.push_back(16'hFFFF);
    // Two high surrogates in a row, the second one paired.
    unit_queue.push_back(16'hD801);
    unit_queue.push_back(16'hDB00);
    unit_queue.push_back(16'hDC05);
    // Lone low surrogates.
    unit_queue.push_back(16'hDFFF);
    unit_queue.push_back(16'hDC00);
    // Terminator with a high surrogate held, then a plain terminator.
    unit_queue.push_back(16'hD900);
    unit_queue.push_back(16'h0000);
    unit_queue.push_back(16'h0000);
    wait_until_drained();

    // The receiver holds off while words keep coming, so the input backs up.
    holds_asked++;
    queue_random_text(RandomUnits / 3);
    wait_until_drained();

    queue_random_text(RandomUnits - RandomUnits / 3);
    unit_queue.push_back(16'h0000);
    wait_until_drained();
    repeat (TailCycles) @(negedge clk);

    if (utf8_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never came out", utf8_bytes_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
